[rtl/ccc_pkg.sv]
// Shared types, constants and codes for the clock-replacement cache controller.
package ccc_pkg;

  localparam int NUM_SLOTS   = 64;
  localparam int SECTOR_BITS = 32;
  localparam int SLOT_IDX_W  = $clog2(NUM_SLOTS);
  localparam int SECTOR_IN_W = 32;
  localparam int SLOT_OUT_W  = 6;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  typedef logic [SLOT_IDX_W-1:0]  slot_idx_t;
  typedef logic [SECTOR_BITS-1:0] tag_t;

  localparam slot_idx_t LAST_SLOT = slot_idx_t'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {
    KIND_READ,
    KIND_WRITE,
    KIND_FLUSH
  } kind_t;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [SECTOR_IN_W-1:0] sector;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0]  slot;
    logic                   hit;
    logic                   writeback;
    logic [SECTOR_IN_W-1:0] writeback_sector;
    logic                   fill;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    kind_t kind;
    tag_t  tag;
  } q_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESOLVE,
    ST_SWEEP,
    ST_VICTIM,
    ST_FLUSH,
    ST_FL_EMIT
  } back_state_t;

endpackage

[rtl/ccc_front.sv]
// Request intake: decodes the opcode, drops unused codes, queues requests for the engine.
module ccc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ccc_pkg::in_item_t  in_data,
  output logic               head_valid,
  output ccc_pkg::q_entry_t  head,
  input  logic               head_pop
);
  import ccc_pkg::*;

  q_entry_t            q_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                keep;
  logic                push;
  kind_t               kind;
  q_entry_t            entry;

  always_comb begin
    keep = 1'b1;
    kind = KIND_READ;
    unique case (in_data.opcode)
      OP_READ:  kind = KIND_READ;
      OP_WRITE: kind = KIND_WRITE;
      OP_FLUSH: kind = KIND_FLUSH;
      default:  keep = 1'b0;   // unused opcode: taken and dropped
    endcase
  end

  assign in_ready   = (count_r != QCNT_W'(QDEPTH));
  assign push       = in_valid && in_ready && keep;
  assign head_valid = (count_r != '0);
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    entry.kind = kind;
    entry.tag  = SECTOR_BITS'(in_data.sector);
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (head_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, head_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> (count_r != '0))
    else $error("queue popped while empty");
`endif

endmodule

[rtl/ccc_back.sv]
// Lookup and policy engine: tag match, clock sweep, victim handling and flush scan.
module ccc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  ccc_pkg::q_entry_t  head,
  output logic               head_pop,
  output logic               res_valid,
  input  logic               res_ready,
  output ccc_pkg::out_item_t res_data
);
  import ccc_pkg::*;

  back_state_t           state_r, state_nxt;
  slot_idx_t             hand_r, hand_nxt;
  slot_idx_t             idx_r, idx_nxt;
  kind_t                 kind_r, kind_nxt;
  tag_t                  tag_r, tag_nxt;
  logic [NUM_SLOTS-1:0]  match_r, match_nxt;
  logic [NUM_SLOTS-1:0]  valid_r, valid_nxt;
  logic [NUM_SLOTS-1:0]  dirty_r, dirty_nxt;
  logic [NUM_SLOTS-1:0]  ref_r, ref_nxt;

  tag_t                  cam_r   [NUM_SLOTS];   // compare copy, one comparator per slot
  tag_t                  tag_mem [NUM_SLOTS];   // read copy for write-back sectors
  tag_t                  rd_data_r;

  logic [NUM_SLOTS-1:0]  match_vec;
  logic [NUM_SLOTS-1:0]  dv;
  logic [NUM_SLOTS-1:0]  above;
  slot_idx_t             hit_idx;
  slot_idx_t             rd_addr;
  slot_idx_t             hand_inc, idx_inc;
  logic                  any_hit;
  logic                  fl_last;
  logic                  victim_wb;
  logic                  mem_we;

  always_comb begin
    for (int j = 0; j < NUM_SLOTS; j++) begin
      match_vec[j] = valid_r[j] && (cam_r[j] == head.tag);
      above[j]     = (SLOT_IDX_W'(j) > idx_r);
    end
  end

  // at most one slot can match, so an OR of the indices encodes it
  always_comb begin
    hit_idx = '0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if (match_r[j]) begin
        hit_idx = hit_idx | SLOT_IDX_W'(j);
      end
    end
  end

  assign any_hit   = |match_r;
  assign dv        = valid_r & dirty_r;
  assign fl_last   = ~|(dv & above);
  assign victim_wb = valid_r[hand_r] && dirty_r[hand_r];
  assign hand_inc  = (hand_r == LAST_SLOT) ? '0 : hand_r + 1'b1;
  assign idx_inc   = (idx_r == LAST_SLOT) ? '0 : idx_r + 1'b1;
  assign rd_addr   = (state_r == ST_FLUSH || state_r == ST_FL_EMIT) ? idx_r : hand_r;

  always_comb begin
    state_nxt = state_r;
    hand_nxt  = hand_r;
    idx_nxt   = idx_r;
    kind_nxt  = kind_r;
    tag_nxt   = tag_r;
    match_nxt = match_r;
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    ref_nxt   = ref_r;
    head_pop  = 1'b0;
    res_valid = 1'b0;
    res_data  = '0;
    mem_we    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (head_valid) begin
          head_pop  = 1'b1;
          kind_nxt  = head.kind;
          tag_nxt   = head.tag;
          match_nxt = match_vec;
          idx_nxt   = '0;
          state_nxt = (head.kind == KIND_FLUSH) ? ST_FLUSH : ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (any_hit) begin
          res_valid     = 1'b1;
          res_data.slot = SLOT_OUT_W'(hit_idx);
          res_data.hit  = 1'b1;
          res_data.last = 1'b1;
          if (res_ready) begin
            ref_nxt[hit_idx] = 1'b1;
            if (kind_r == KIND_WRITE) begin
              dirty_nxt[hit_idx] = 1'b1;
            end
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (ref_r[hand_r]) begin
          ref_nxt[hand_r] = 1'b0;   // second chance used up
          hand_nxt        = hand_inc;
        end else begin
          state_nxt = ST_VICTIM;
        end
      end
      ST_VICTIM: begin
        res_valid                 = 1'b1;
        res_data.slot             = SLOT_OUT_W'(hand_r);
        res_data.writeback        = victim_wb;
        res_data.writeback_sector = victim_wb ? SECTOR_IN_W'(rd_data_r) : '0;
        res_data.fill             = 1'b1;
        res_data.last             = 1'b1;
        if (res_ready) begin
          mem_we            = 1'b1;
          valid_nxt[hand_r] = 1'b1;
          dirty_nxt[hand_r] = (kind_r == KIND_WRITE);
          ref_nxt[hand_r]   = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (dv[idx_r]) begin
          state_nxt = ST_FL_EMIT;
        end else if (idx_r == LAST_SLOT) begin
          valid_nxt = '0;
          dirty_nxt = '0;
          ref_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      ST_FL_EMIT: begin
        res_valid                 = 1'b1;
        res_data.slot             = SLOT_OUT_W'(idx_r);
        res_data.writeback        = 1'b1;
        res_data.writeback_sector = SECTOR_IN_W'(rd_data_r);
        res_data.last             = fl_last;
        if (res_ready) begin
          if (fl_last) begin
            valid_nxt = '0;
            dirty_nxt = '0;
            ref_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = ST_FLUSH;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hand_r  <= '0;
      idx_r   <= '0;
      kind_r  <= KIND_READ;
      valid_r <= '0;
      dirty_r <= '0;
      ref_r   <= '0;
    end else begin
      state_r <= state_nxt;
      hand_r  <= hand_nxt;
      idx_r   <= idx_nxt;
      kind_r  <= kind_nxt;
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      ref_r   <= ref_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r   <= tag_nxt;
    match_r <= match_nxt;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= tag_mem[rd_addr];
    if (mem_we) begin
      tag_mem[hand_r] <= tag_r;
      cam_r[hand_r]   <= tag_r;
    end
  end

`ifndef ASSERT_OFF
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESOLVE) |-> $onehot0(match_r))
    else $error("sector matched in more than one slot");

  a_victim_unref: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VICTIM) |-> !ref_r[hand_r])
    else $error("victim slot still referenced");

  a_flush_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FL_EMIT) |-> dv[idx_r])
    else $error("flush reporting a clean or invalid slot");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FL_EMIT && res_ready && fl_last) |=>
      (valid_r == '0 && dirty_r == '0 && ref_r == '0))
    else $error("flags not cleared after flush");
`endif

endmodule

[rtl/clock_buffer_cache_controller.sv]
// Top level of the clock-replacement write-back cache controller with its output stage.
// Path: a hit is popped from the queue, resolved by tag, then registered onto out_data;
//   a miss then sweeps past referenced slots (up to NUM_SLOTS) and emits the victim.
// Order: a hit takes queue pop, then tag resolve; the engine pops the next one once idle;
//   a flush scans to the last dirty slot (or the end), reading each dirty one's tag first.
// Reset (rst_n, synchronous, active low) clears state, flags, hand, queue and out_valid only.
module clock_buffer_cache_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ccc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ccc_pkg::out_item_t out_data
);
  import ccc_pkg::*;

  // front-to-back queue head
  logic       head_valid;
  q_entry_t   head;
  logic       head_pop;

  // engine result into the output register
  logic       res_valid;
  logic       res_ready;
  out_item_t  res_data;

  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r;

  // front: opcode decode and a short request queue, so intake keeps
  // running while the engine sweeps or scans
  ccc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  // back: tag compare, clock replacement, write-back/fill decision, flush
  ccc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

  // output register: the engine can hand over a new transaction in the
  // same cycle the held one leaves
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
